### sv/rau_pkg.sv
// rau_pkg: shared widths, codes, states and divider request and response types for the rational unit
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
    localparam int MUL_WIDTH     = OPERAND_WIDTH + 1;
    localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
    localparam int RES_NUM_WIDTH = 2 * OPERAND_WIDTH;
    localparam int RES_DEN_WIDTH = 2 * OPERAND_WIDTH - 2;
    localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH - 1;
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH);
    localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);
    localparam int MUL_STEPS     = 3;
    localparam int IDX_WIDTH     = $clog2(MUL_STEPS);

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_GCD,
        ST_QNUM,
        ST_WNUM,
        ST_QDEN,
        ST_WDEN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic [MAG_WIDTH-1:0]     dividend;
        logic [RES_DEN_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [MAG_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

### sv/rau_div.sv
// rau_div: restoring divider, one quotient bit per cycle
module rau_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rau_pkg::CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [rau_pkg::RES_DEN_WIDTH-1:0] rem_reg, rem_next;
    logic [rau_pkg::MAG_WIDTH-1:0]     quo_reg, quo_next;
    logic [rau_pkg::RES_DEN_WIDTH-1:0] dsr_reg, dsr_next;

    logic [rau_pkg::MAG_WIDTH-1:0]     trial;
    logic [rau_pkg::MAG_WIDTH-1:0]     diff;
    logic                              ge;

    assign trial = {rem_reg, quo_reg[rau_pkg::MAG_WIDTH-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[rau_pkg::RES_DEN_WIDTH-1:0]
                          : trial[rau_pkg::RES_DEN_WIDTH-1:0];
            quo_next = {quo_reg[rau_pkg::MAG_WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rau_pkg::CNT_WIDTH'(rau_pkg::MAG_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/rational_arithmetic_unit_top.sv
// rational_arithmetic_unit_top: fraction add/sub/mul/div with gcd reduction
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  request  | s_valid / s_ready  | s_func, s_a_num, s_a_den, s_b_num, s_b_den
//  result   | m_valid / m_ready  | m_res_num, m_res_den, m_status
//
//  one request at a time; s_ready is high only while the sequencer is idle
//  the three cross products share one 17x17 multiplier, both reductions share one divider
//  bad operands and zero numerators skip straight to the result register
//  result register holds until taken; a stall on m_ready delays the next request
//  aresetn is synchronous and clears the sequencer and m_valid
module rational_arithmetic_unit_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_func,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_num,
    input  logic [rau_pkg::DEN_WIDTH-1:0]           s_a_den,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_num,
    input  logic [rau_pkg::DEN_WIDTH-1:0]           s_b_den,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [rau_pkg::RES_NUM_WIDTH-1:0] m_res_num,
    output logic [rau_pkg::RES_DEN_WIDTH-1:0]       m_res_den,
    output logic                                    m_status
);

    rau_pkg::state_t state_reg, state_next;
    rau_pkg::func_t  func_reg, func_next;

    logic signed [rau_pkg::OPERAND_WIDTH-1:0] an_reg, an_next, bn_reg, bn_next;
    logic [rau_pkg::DEN_WIDTH-1:0]            ad_reg, ad_next, bd_reg, bd_next;
    logic [rau_pkg::IDX_WIDTH-1:0]            idx_reg, idx_next;
    logic signed [rau_pkg::RES_NUM_WIDTH-1:0] prod_reg, prod_next;
    logic signed [rau_pkg::RES_NUM_WIDTH-1:0] num_reg, num_next;
    logic signed [rau_pkg::RES_NUM_WIDTH-1:0] den_reg, den_next;
    logic                                     neg_reg, neg_next;
    logic                                     err_reg, err_next;
    logic [rau_pkg::MAG_WIDTH-1:0]            mag_reg, mag_next;
    logic [rau_pkg::RES_DEN_WIDTH-1:0]        dv_reg, dv_next;
    logic [rau_pkg::MAG_WIDTH-1:0]            gx_reg, gx_next, gy_reg, gy_next;
    logic [rau_pkg::SHIFT_WIDTH-1:0]          k_reg, k_next;
    logic [rau_pkg::RES_DEN_WIDTH-1:0]        g_reg, g_next;

    logic                                     m_valid_reg, m_valid_next;
    logic signed [rau_pkg::RES_NUM_WIDTH-1:0] m_num_reg, m_num_next;
    logic [rau_pkg::RES_DEN_WIDTH-1:0]        m_den_reg, m_den_next;
    logic                                     m_status_reg, m_status_next;

    logic                                     in_err;
    logic                                     load_out;
    logic signed [rau_pkg::MUL_WIDTH-1:0]     an_x, ad_x, bn_x, bd_x, mul_a, mul_b;
    logic signed [rau_pkg::PROD_WIDTH-1:0]    mul_full;
    logic signed [rau_pkg::RES_NUM_WIDTH-1:0] fin_den_raw, fin_num, fin_den;
    logic                                     flip, fin_neg;
    logic [rau_pkg::RES_NUM_WIDTH-1:0]        fin_abs;
    logic                                     gcd_eq, gcd_gt;
    logic [rau_pkg::MAG_WIDTH-1:0]            sub_a, sub_b, sub_d, g_wide;
    logic [rau_pkg::RES_NUM_WIDTH-1:0]        out_mag;

    rau_pkg::div_req_t div_req;
    rau_pkg::div_rsp_t div_rsp;

    rau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign in_err = (s_a_den == '0) || (s_b_den == '0) ||
                    ((rau_pkg::func_t'(s_func) == rau_pkg::FUNC_DIV) && (s_b_num == '0));

    // shared multiplier operands
    assign an_x = {an_reg[rau_pkg::OPERAND_WIDTH-1], an_reg};
    assign bn_x = {bn_reg[rau_pkg::OPERAND_WIDTH-1], bn_reg};
    assign ad_x = {2'b00, ad_reg};
    assign bd_x = {2'b00, bd_reg};

    always_comb begin
        case (idx_reg)
            rau_pkg::IDX_WIDTH'(0): begin
                mul_a = an_x;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? bn_x : bd_x;
            end
            rau_pkg::IDX_WIDTH'(1): begin
                mul_a = ad_x;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? bd_x : bn_x;
            end
            default: begin
                mul_a = ad_x;
                mul_b = bd_x;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // sign fix-up and magnitude
    assign fin_den_raw = ((func_reg == rau_pkg::FUNC_ADD) || (func_reg == rau_pkg::FUNC_SUB))
                         ? prod_reg : den_reg;
    assign flip    = fin_den_raw < 0;
    assign fin_num = flip ? -num_reg : num_reg;
    assign fin_den = flip ? -fin_den_raw : fin_den_raw;
    assign fin_neg = fin_num < 0;
    assign fin_abs = fin_neg ? -fin_num : fin_num;

    // binary gcd step
    assign gcd_eq = gx_reg == gy_reg;
    assign gcd_gt = gx_reg > gy_reg;
    assign sub_a  = gcd_gt ? gx_reg : gy_reg;
    assign sub_b  = gcd_gt ? gy_reg : gx_reg;
    assign sub_d  = sub_a - sub_b;
    assign g_wide = gx_reg << k_reg;

    assign out_mag = {1'b0, mag_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_err ? rau_pkg::ST_OUT : rau_pkg::ST_MUL;
                end
            end
            rau_pkg::ST_MUL: begin
                if (idx_reg == rau_pkg::IDX_WIDTH'(rau_pkg::MUL_STEPS - 1)) begin
                    state_next = rau_pkg::ST_FIX;
                end
            end
            rau_pkg::ST_FIX: begin
                state_next = (fin_num == '0) ? rau_pkg::ST_OUT : rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD: begin
                if (gcd_eq) begin
                    state_next = rau_pkg::ST_QNUM;
                end
            end
            rau_pkg::ST_QNUM: state_next = rau_pkg::ST_WNUM;
            rau_pkg::ST_WNUM: begin
                if (div_rsp.done) begin
                    state_next = rau_pkg::ST_QDEN;
                end
            end
            rau_pkg::ST_QDEN: state_next = rau_pkg::ST_WDEN;
            rau_pkg::ST_WDEN: begin
                if (div_rsp.done) begin
                    state_next = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready          = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = g_reg;
        case (state_reg)
            rau_pkg::ST_IDLE: s_ready = 1'b1;
            rau_pkg::ST_QNUM: div_req.start = 1'b1;
            rau_pkg::ST_QDEN: begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, dv_reg};
            end
            rau_pkg::ST_OUT:  load_out = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        func_next = func_reg;
        an_next   = an_reg;
        bn_next   = bn_reg;
        ad_next   = ad_reg;
        bd_next   = bd_reg;
        idx_next  = idx_reg;
        prod_next = prod_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        err_next  = err_reg;
        mag_next  = mag_reg;
        dv_next   = dv_reg;
        gx_next   = gx_reg;
        gy_next   = gy_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                func_next = rau_pkg::func_t'(s_func);
                an_next   = s_a_num;
                bn_next   = s_b_num;
                ad_next   = s_a_den;
                bd_next   = s_b_den;
                idx_next  = '0;
                neg_next  = 1'b0;
                err_next  = in_err;
                mag_next  = '0;
                dv_next   = rau_pkg::RES_DEN_WIDTH'(1);
            end
            rau_pkg::ST_MUL: begin
                prod_next = mul_full[rau_pkg::RES_NUM_WIDTH-1:0];
                idx_next  = idx_reg + 1'b1;
                case (idx_reg)
                    rau_pkg::IDX_WIDTH'(0): ;
                    rau_pkg::IDX_WIDTH'(1): num_next = prod_reg;
                    default: begin
                        case (func_reg)
                            rau_pkg::FUNC_ADD: num_next = num_reg + prod_reg;
                            rau_pkg::FUNC_SUB: num_next = num_reg - prod_reg;
                            default:           den_next = prod_reg;
                        endcase
                    end
                endcase
            end
            rau_pkg::ST_FIX: begin
                neg_next = fin_neg;
                mag_next = fin_abs[rau_pkg::MAG_WIDTH-1:0];
                dv_next  = (fin_num == '0) ? rau_pkg::RES_DEN_WIDTH'(1)
                                           : fin_den[rau_pkg::RES_DEN_WIDTH-1:0];
                gx_next  = fin_abs[rau_pkg::MAG_WIDTH-1:0];
                gy_next  = {1'b0, fin_den[rau_pkg::RES_DEN_WIDTH-1:0]};
                k_next   = '0;
            end
            rau_pkg::ST_GCD: begin
                if (gcd_eq) begin
                    g_next = g_wide[rau_pkg::RES_DEN_WIDTH-1:0];
                end else if (!gx_reg[0] && !gy_reg[0]) begin
                    gx_next = gx_reg >> 1;
                    gy_next = gy_reg >> 1;
                    k_next  = k_reg + 1'b1;
                end else if (!gx_reg[0]) begin
                    gx_next = gx_reg >> 1;
                end else if (!gy_reg[0]) begin
                    gy_next = gy_reg >> 1;
                end else if (gcd_gt) begin
                    gx_next = sub_d;
                end else begin
                    gy_next = sub_d;
                end
            end
            rau_pkg::ST_WNUM: begin
                if (div_rsp.done) begin
                    mag_next = div_rsp.quotient;
                end
            end
            rau_pkg::ST_WDEN: begin
                if (div_rsp.done) begin
                    dv_next = div_rsp.quotient[rau_pkg::RES_DEN_WIDTH-1:0];
                end
            end
            default: ;
        endcase
    end

    // result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_num_next    = m_num_reg;
        m_den_next    = m_den_reg;
        m_status_next = m_status_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_num_next    = neg_reg ? -$signed(out_mag) : $signed(out_mag);
            m_den_next    = dv_reg;
            m_status_next = err_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg     <= func_next;
        an_reg       <= an_next;
        bn_reg       <= bn_next;
        ad_reg       <= ad_next;
        bd_reg       <= bd_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        err_reg      <= err_next;
        mag_reg      <= mag_next;
        dv_reg       <= dv_next;
        gx_reg       <= gx_next;
        gy_reg       <= gy_next;
        k_reg        <= k_next;
        g_reg        <= g_next;
        m_num_reg    <= m_num_next;
        m_den_reg    <= m_den_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_res_num = m_num_reg;
    assign m_res_den = m_den_reg;
    assign m_status  = m_status_reg;

endmodule

### sv/rau_checker.sv
// rau_checker: port-level assertions for the rational unit, bound to the top level
module rau_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [rau_pkg::RES_NUM_WIDTH-1:0] m_res_num,
    input logic [rau_pkg::RES_DEN_WIDTH-1:0]       m_res_den,
    input logic                                    m_status
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_num) && $stable(m_res_den)
                                && $stable(m_status))
        else $error("stalled result changed");

    // one request in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_res_den != '0)
        else $error("zero result denominator");

    a_err_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_res_num == '0 && m_res_den == rau_pkg::RES_DEN_WIDTH'(1))
        else $error("error result not 0/1");

    a_zero_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res_num == '0 |-> m_res_den == rau_pkg::RES_DEN_WIDTH'(1))
        else $error("zero numerator not over 1");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);

### verif/tb_top.sv
// tb_top: self-checking testbench for rational_arithmetic_unit_top with its own fraction predictor
`timescale 1ns / 100ps

module tb_top;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;
    localparam int   RANDOM_REQS = 1500;
    localparam int   TAIL_CYCLES = 300;
    localparam int   CYCLE_LIMIT = 2_000_000;
    localparam int   PRINT_LIMIT = 100;

    typedef struct {
        logic signed [rau_pkg::RES_NUM_WIDTH-1:0] num;
        logic [rau_pkg::RES_DEN_WIDTH-1:0]        den;
        logic                                     status;
    } frac_res_t;

    typedef struct {
        rau_pkg::func_t                           func;
        logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num;
        logic [rau_pkg::DEN_WIDTH-1:0]            a_den;
        logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num;
        logic [rau_pkg::DEN_WIDTH-1:0]            b_den;
        bit                                       typed;
        frac_res_t                                typed_res;
    } frac_req_t;

    logic                                     aclk;
    logic                                     aresetn;
    logic                                     s_valid;
    logic                                     s_ready;
    logic [1:0]                               s_func;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_num;
    logic [rau_pkg::DEN_WIDTH-1:0]            s_a_den;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_num;
    logic [rau_pkg::DEN_WIDTH-1:0]            s_b_den;
    logic                                     m_valid;
    logic                                     m_ready;
    logic signed [rau_pkg::RES_NUM_WIDTH-1:0] m_res_num;
    logic [rau_pkg::RES_DEN_WIDTH-1:0]        m_res_den;
    logic                                     m_status;

    frac_req_t request_q[$];
    frac_res_t reduced_q[$];
    frac_req_t cur_req;
    frac_res_t want_res;
    int        err_cnt = 0;
    int        res_cnt = 0;
    int        cycle_cnt = 0;
    int        burst_left = 0;
    int        rdy_mode = 0;
    int        rdy_left = 0;

    rational_arithmetic_unit_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_status  (m_status)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    function automatic frac_res_t reduce_fraction(frac_req_t r);
        longint    an, ad, bn, bd, num, den, x, y, t;
        frac_res_t res;
        an = longint'(r.a_num);
        ad = longint'(r.a_den);
        bn = longint'(r.b_num);
        bd = longint'(r.b_den);
        res.num = '0;
        res.den = rau_pkg::RES_DEN_WIDTH'(1);
        res.status = STATUS_OK;
        if (ad == 0 || bd == 0) begin
            res.status = STATUS_ERR;
            return res;
        end
        case (r.func)
            rau_pkg::FUNC_ADD: begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            rau_pkg::FUNC_SUB: begin
                num = an * bd - ad * bn;
                den = ad * bd;
            end
            rau_pkg::FUNC_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                if (bn == 0) begin
                    res.status = STATUS_ERR;
                    return res;
                end
                num = an * bd;
                den = ad * bn;
                if (den < 0) begin
                    num = -num;
                    den = -den;
                end
            end
        endcase
        if (num == 0)
            return res;
        x = (num < 0) ? -num : num;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        res.num = rau_pkg::RES_NUM_WIDTH'(num / x);
        res.den = rau_pkg::RES_DEN_WIDTH'(den / x);
        return res;
    endfunction

    task automatic add_row(input rau_pkg::func_t f, input int an, input int ad, input int bn,
                           input int bd, input bit typed, input longint en, input longint ed,
                           input logic es);
        frac_req_t r;
        r.func = f;
        r.a_num = rau_pkg::OPERAND_WIDTH'(an);
        r.a_den = rau_pkg::DEN_WIDTH'(ad);
        r.b_num = rau_pkg::OPERAND_WIDTH'(bn);
        r.b_den = rau_pkg::DEN_WIDTH'(bd);
        r.typed = typed;
        r.typed_res.num = rau_pkg::RES_NUM_WIDTH'(en);
        r.typed_res.den = rau_pkg::RES_DEN_WIDTH'(ed);
        r.typed_res.status = es;
        request_q.push_back(r);
    endtask

    function automatic logic signed [rau_pkg::OPERAND_WIDTH-1:0] pick_num();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return {1'b1, {(rau_pkg::OPERAND_WIDTH-1){1'b0}}};
            2:       return rau_pkg::OPERAND_WIDTH'(32767);
            3:       return rau_pkg::OPERAND_WIDTH'(-32767);
            4, 5:    return rau_pkg::OPERAND_WIDTH'($signed($urandom_range(0, 32)) - 16);
            default: return rau_pkg::OPERAND_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [rau_pkg::DEN_WIDTH-1:0] pick_den();
        case ($urandom_range(0, 31))
            0:             return '0;
            1, 2:          return rau_pkg::DEN_WIDTH'(1);
            3, 4:          return {rau_pkg::DEN_WIDTH{1'b1}};
            5, 6, 7, 8, 9: return rau_pkg::DEN_WIDTH'($urandom_range(1, 24));
            default:       return rau_pkg::DEN_WIDTH'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic frac_req_t random_request();
        frac_req_t r;
        r.func = rau_pkg::func_t'($urandom_range(0, 3));
        r.a_num = pick_num();
        r.a_den = pick_den();
        if ($urandom_range(0, 9) == 0) begin
            r.b_num = r.a_num;
            r.b_den = r.a_den;
        end else begin
            r.b_num = pick_num();
            r.b_den = pick_den();
        end
        r.typed = 1'b0;
        r.typed_res.num = '0;
        r.typed_res.den = rau_pkg::RES_DEN_WIDTH'(1);
        r.typed_res.status = STATUS_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0d want %0d", res_cnt, what, got, want);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(1, 400);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (rdy_left[4:0] == 5'd0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                reduced_q.push_back(cur_req.typed ? cur_req.typed_res : reduce_fraction(cur_req));
            if (m_valid && m_ready) begin
                res_cnt++;
                if (reduced_q.size() == 0) begin
                    report_mismatch("result with no request pending", longint'(m_res_num), 0);
                end else begin
                    want_res = reduced_q.pop_front();
                    if (m_res_num !== want_res.num)
                        report_mismatch("res_num", longint'(m_res_num), longint'(want_res.num));
                    if (m_res_den !== want_res.den)
                        report_mismatch("res_den", longint'(m_res_den), longint'(want_res.den));
                    if (m_status !== want_res.status)
                        report_mismatch("status", longint'(m_status),
                                        longint'(want_res.status));
                end
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAIL rational_arithmetic_unit_top");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = rau_pkg::FUNC_ADD;
        s_a_num = '0;
        s_a_den = '0;
        s_b_num = '0;
        s_b_den = '0;

        add_row(rau_pkg::FUNC_ADD, 1, 2, 1, 3, 1, 5, 6, STATUS_OK);
        add_row(rau_pkg::FUNC_ADD, 0, 1, 0, 5, 1, 0, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_SUB, 3, 4, 3, 4, 1, 0, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_SUB, 1, 2, 3, 4, 0, 0, 0, STATUS_OK);
        add_row(rau_pkg::FUNC_MUL, 2, 3, 3, 2, 1, 1, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_MUL, 32767, 1, 32767, 1, 1, 1073676289, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_ADD, -32768, 32767, -32768, 32767, 0, 0, 0, STATUS_OK);
        add_row(rau_pkg::FUNC_ADD, 32767, 32767, 32767, 32767, 1, 2, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_DIV, 1, 2, 0, 7, 1, 0, 1, STATUS_ERR);
        add_row(rau_pkg::FUNC_DIV, 3, 5, -3, 7, 0, 0, 0, STATUS_OK);
        add_row(rau_pkg::FUNC_DIV, -32768, 1, -32768, 1, 1, 1, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_DIV, 1, 32767, 32767, 1, 1, 1, 1073676289, STATUS_OK);
        add_row(rau_pkg::FUNC_ADD, 5, 0, 1, 3, 1, 0, 1, STATUS_ERR);
        add_row(rau_pkg::FUNC_MUL, 5, 3, 1, 0, 1, 0, 1, STATUS_ERR);
        add_row(rau_pkg::FUNC_DIV, 7, 0, 0, 9, 1, 0, 1, STATUS_ERR);
        add_row(rau_pkg::FUNC_SUB, -32768, 1, 32767, 1, 1, -65535, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_DIV, 5, 1, -1, 1, 1, -5, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_MUL, 0, 9, -32768, 32767, 1, 0, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_DIV, 0, 3, 5, 7, 1, 0, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_SUB, 12345, 30000, -23456, 17, 0, 0, 0, STATUS_OK);
        add_row(rau_pkg::FUNC_ADD, -1, 32767, 1, 32767, 1, 0, 1, STATUS_OK);
        add_row(rau_pkg::FUNC_DIV, -32768, 32767, 32767, 1, 0, 0, 0, STATUS_OK);
        repeat (RANDOM_REQS) request_q.push_back(random_request());

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (request_q[i]) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 25)) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            s_valid <= 1'b1;
            s_func  <= request_q[i].func;
            s_a_num <= request_q[i].a_num;
            s_a_den <= request_q[i].a_den;
            s_b_num <= request_q[i].b_num;
            s_b_den <= request_q[i].b_den;
            cur_req <= request_q[i];
            do @(posedge aclk); while (!s_ready);
            burst_left--;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (reduced_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("PASS rational_arithmetic_unit_top");
        else
            $display("FAIL rational_arithmetic_unit_top");
        $finish;
    end

endmodule
